// ===== rtl/tp20_pkg.sv =====
package tp20_pkg;

    // Frame length limit and keep-alive limit of the session.
    localparam int unsigned KEEPALIVE_LIMIT = 10;
    localparam int unsigned MAX_FRAME_BYTES = 16;

    localparam int unsigned LEN_W = 5;
    localparam int unsigned CNT_W = 4;
    localparam int unsigned RLEN_W = 16;
    localparam int unsigned XLEN_W = 12;
    localparam int unsigned SEQ_W = 4;
    localparam int unsigned IN_DATA_W = 48;
    localparam int unsigned OUT_DATA_W = 8;

    // Opcodes and response codes found in the frame header.
    localparam logic [7:0] OP_KEEPALIVE = 8'hA3;
    localparam logic [7:0] OP_WAIT = 8'hA1;
    localparam logic [7:0] NEG_RESP = 8'h7F;
    localparam logic [7:0] RESP_PENDING = 8'h78;
    localparam int unsigned MORE_BIT = 7;

    // Length thresholds.
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(4);
    localparam logic [LEN_W-1:0] LEN_BUSY_MIN = LEN_W'(7);
    localparam logic [LEN_W-1:0] LEN_FIRST_HDR = LEN_W'(6);
    localparam logic [LEN_W-1:0] LEN_CONT_HDR = LEN_W'(4);

    // One received frame header.
    typedef struct packed {
        logic [7:0]       code_byte;
        logic [7:0]       service_byte;
        logic [7:0]       len_low_byte;
        logic [7:0]       len_high_byte;
        logic [7:0]       op_byte;
        logic [LEN_W-1:0] frame_length;
    } tp20_item_t;

    // Session state.
    typedef struct packed {
        logic              in_message;
        logic [CNT_W-1:0]  keepalive_count;
        logic [7:0]        busy_seen;
        logic [RLEN_W-1:0] received_len;
        logic [XLEN_W-1:0] expected_len;
        logic [SEQ_W-1:0]  last_seq;
        logic              more_follow;
    } tp20_state_t;

    // One result.
    typedef struct packed {
        logic             status;
        logic             finished;
        logic [SEQ_W-1:0] ack_seq;
        logic             send_ack;
        logic             send_keepalive;
        logic             store_frame;
    } tp20_result_t;

    localparam tp20_state_t STATE_RESET = '{
        in_message:      1'b0,
        keepalive_count: '0,
        busy_seen:       '0,
        received_len:    '0,
        expected_len:    '0,
        last_seq:        '0,
        more_follow:     1'b1
    };

endpackage

// ===== rtl/tp20_step.sv =====
module tp20_step (
    input  tp20_pkg::tp20_state_t  st,
    input  tp20_pkg::tp20_item_t   item,
    input  logic [7:0]             busy_limit,
    output tp20_pkg::tp20_state_t  st_next,
    output tp20_pkg::tp20_result_t res
);
    import tp20_pkg::*;

    // Session decision for one frame header.
    always_comb
    begin
        logic [LEN_W-1:0]  len;
        logic [RLEN_W-1:0] rlen;
        logic [7:0]        busy_cnt;
        logic [CNT_W-1:0]  ka_cnt;
        logic              fin;
        logic              done;

        st_next = st;
        res = '0;
        fin = 1'b0;
        done = 1'b0;
        len = (item.frame_length > LEN_MAX) ? LEN_MAX : item.frame_length;
        rlen = st.received_len + RLEN_W'(len) - RLEN_W'(LEN_CONT_HDR);
        busy_cnt = st.busy_seen + 8'd1;
        ka_cnt = st.keepalive_count + CNT_W'(1);

        if (st.in_message)
        begin
            // Continuation frame or timeout inside a message.
            if (len == '0)
            begin
                done = 1'b1;
            end
            else
            begin
                st_next.received_len = rlen;
                st_next.last_seq = item.op_byte[SEQ_W-1:0];
                res.store_frame = 1'b1;
                done = (rlen >= RLEN_W'(st.expected_len));
            end
            if (done)
            begin
                st_next.in_message = 1'b0;
                res.send_ack = 1'b1;
                res.ack_seq = st_next.last_seq + SEQ_W'(1);
                if (!st.more_follow)
                begin
                    fin = 1'b1;
                    res.status = 1'b1;
                end
            end
        end
        else if (len == '0)
        begin
            // Timeout between messages.
            fin = 1'b1;
            res.status = 1'b1;
        end
        else if (len <= LEN_SHORT)
        begin
            // Short frame: only a keep-alive is acted on.
            if (item.op_byte == OP_KEEPALIVE)
            begin
                res.send_keepalive = 1'b1;
                st_next.keepalive_count = ka_cnt;
                if (ka_cnt == CNT_W'(KEEPALIVE_LIMIT))
                begin
                    fin = 1'b1;
                end
            end
        end
        else if (len >= LEN_BUSY_MIN && item.service_byte == NEG_RESP
                 && item.code_byte == RESP_PENDING)
        begin
            // Busy response: acknowledge and count.
            st_next.busy_seen = busy_cnt;
            res.send_ack = 1'b1;
            res.ack_seq = item.op_byte[SEQ_W-1:0] + SEQ_W'(1);
            if (busy_cnt == busy_limit)
            begin
                res.store_frame = 1'b1;
                fin = 1'b1;
                res.status = 1'b1;
            end
        end
        else if (len > LEN_BUSY_MIN && item.op_byte == OP_WAIT)
        begin
            // Wait frame ends the receive.
            res.store_frame = 1'b1;
            fin = 1'b1;
            res.status = 1'b1;
        end
        else
        begin
            // First frame of a message.
            st_next.more_follow = item.len_high_byte[MORE_BIT];
            st_next.received_len = RLEN_W'(len) - RLEN_W'(LEN_FIRST_HDR);
            st_next.expected_len = {item.len_high_byte[3:0], item.len_low_byte};
            st_next.last_seq = item.op_byte[SEQ_W-1:0];
            res.store_frame = 1'b1;
            if (st_next.received_len < RLEN_W'(st_next.expected_len))
            begin
                st_next.in_message = 1'b1;
            end
            else
            begin
                res.send_ack = 1'b1;
                res.ack_seq = st_next.last_seq + SEQ_W'(1);
                if (!item.len_high_byte[MORE_BIT])
                begin
                    fin = 1'b1;
                    res.status = 1'b1;
                end
            end
        end

        res.finished = fin;
        if (fin)
        begin
            st_next = STATE_RESET;
        end
    end

endmodule

// ===== rtl/tp20_frame_receiver_unit.sv =====
// Receive side of a TP2.0 transport session. Each request on the slave side
// is one received CAN frame header; each produces exactly one request on the
// master side telling whether to store the frame, send a keep-alive reply or
// an ACK (with its sequence), and whether the receive finished (m_tlast) and
// with what status. An input request is registered, decided by combinational
// logic against the session state, and written to the result register, so a
// new frame is taken every cycle while the result side keeps up; a stalled
// result holds back at most one frame in the input register. Write busy_limit
// only while idle.
module tp20_frame_receiver_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [7:0]                        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // frame_length[4:0], op_byte[12:5], len_high_byte[20:13],
    // len_low_byte[28:21], service_byte[36:29], code_byte[44:37], zeros above
    input  logic [tp20_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // store_frame[0], send_keepalive[1], send_ack[2], ack_seq[6:3], status[7]
    output logic [tp20_pkg::OUT_DATA_W-1:0]   m_tdata,
    // finished
    output logic                              m_tlast
);
    import tp20_pkg::*;

    logic         in_valid_reg;
    tp20_item_t   in_item_reg;
    logic         out_valid_reg;
    tp20_result_t out_res_reg;
    tp20_state_t  state_reg;
    tp20_state_t  state_next;
    tp20_result_t res_next;
    logic [7:0]   busy_limit_reg;
    logic         advance;

    // A held frame moves to the result register when that register is free or is being read.
    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_limit_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            busy_limit_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= tp20_item_t'(s_tdata[$bits(tp20_item_t)-1:0]);
        end
    end

    // Session decision logic.
    tp20_step u_step (
        .st         (state_reg),
        .item       (in_item_reg),
        .busy_limit (busy_limit_reg),
        .st_next    (state_next),
        .res        (res_next)
    );

    // Session state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast = out_res_reg.finished;
    assign m_tdata = {out_res_reg.status, out_res_reg.ack_seq, out_res_reg.send_ack,
                      out_res_reg.send_keepalive, out_res_reg.store_frame};

    // A finished receive leaves the session in its reset state.
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.finished |=> state_reg == STATE_RESET)
        else $error("session state not cleared after finish");

    // The keep-alive count never passes its limit.
    a_ka_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.keepalive_count <= CNT_W'(KEEPALIVE_LIMIT))
        else $error("keep-alive count beyond limit");

    // Sequence and status are zero unless the ACK or finish goes with them.
    a_res_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_res_reg.send_ack || out_res_reg.ack_seq == '0)
                     && (out_res_reg.finished || !out_res_reg.status))
        else $error("stray ack sequence or status");

    // An empty input register always takes a request.
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import tp20_pkg::*;

    localparam int CLK_HALF = 2;
    localparam int RESET_CYCLES = 9;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_CONT_FRAMES = 700;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [7:0]            cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Tracks the session state and the actions expected for each frame.
    class tp20_session_tracker;
        logic [7:0]        busy_limit;
        logic              in_message;
        logic [CNT_W-1:0]  ka_count;
        logic [7:0]        busy_seen;
        logic [RLEN_W-1:0] rx_len;
        logic [XLEN_W-1:0] exp_len;
        logic [SEQ_W-1:0]  last_seq;
        logic              more_follow;
        tp20_result_t      frame_actions_q[$];
        int                errors;

        function new();
            busy_limit = 8'd1;
            errors = 0;
            clear_session();
        endfunction

        function void clear_session();
            in_message = 1'b0;
            ka_count = '0;
            busy_seen = '0;
            rx_len = '0;
            exp_len = '0;
            last_seq = '0;
            more_follow = 1'b1;
        endfunction

        function int pending();
            return frame_actions_q.size();
        endfunction

        // Works out the actions for one accepted frame. Returns 1 when the
        // block does something with the frame rather than ignoring it.
        function bit note_frame(tp20_item_t f);
            tp20_result_t     r;
            logic [LEN_W-1:0] len;
            bit               done;
            r = '0;
            done = 1'b0;
            len = (f.frame_length > LEN_MAX) ? LEN_MAX : f.frame_length;
            if (in_message)
            begin
                // Continuation frame or a timeout inside the message.
                if (len == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    rx_len = rx_len + RLEN_W'(len) - RLEN_W'(LEN_CONT_HDR);
                    last_seq = f.op_byte[SEQ_W-1:0];
                    r.store_frame = 1'b1;
                    if (rx_len >= RLEN_W'(exp_len))
                        done = 1'b1;
                end
                if (done)
                begin
                    in_message = 1'b0;
                    r.send_ack = 1'b1;
                    r.ack_seq = last_seq + 4'd1;
                    if (!more_follow)
                    begin
                        r.finished = 1'b1;
                        r.status = 1'b1;
                    end
                end
            end
            else if (len == '0)
            begin
                r.finished = 1'b1;
                r.status = 1'b1;
            end
            else if (len <= LEN_SHORT)
            begin
                // Short frames only matter when they are keep-alives.
                if (f.op_byte == OP_KEEPALIVE)
                begin
                    r.send_keepalive = 1'b1;
                    ka_count = ka_count + 4'd1;
                    if (ka_count == CNT_W'(KEEPALIVE_LIMIT))
                        r.finished = 1'b1;
                end
            end
            else if (len >= LEN_BUSY_MIN && f.service_byte == NEG_RESP &&
                     f.code_byte == RESP_PENDING)
            begin
                busy_seen = busy_seen + 8'd1;
                r.send_ack = 1'b1;
                r.ack_seq = f.op_byte[SEQ_W-1:0] + 4'd1;
                if (busy_seen == busy_limit)
                begin
                    r.store_frame = 1'b1;
                    r.finished = 1'b1;
                    r.status = 1'b1;
                end
            end
            else if (len > LEN_BUSY_MIN && f.op_byte == OP_WAIT)
            begin
                r.store_frame = 1'b1;
                r.finished = 1'b1;
                r.status = 1'b1;
            end
            else
            begin
                // First frame of a message.
                more_follow = f.len_high_byte[MORE_BIT];
                rx_len = RLEN_W'(len) - RLEN_W'(LEN_FIRST_HDR);
                exp_len = {f.len_high_byte[3:0], f.len_low_byte};
                last_seq = f.op_byte[SEQ_W-1:0];
                r.store_frame = 1'b1;
                if (rx_len < RLEN_W'(exp_len))
                begin
                    in_message = 1'b1;
                end
                else
                begin
                    r.send_ack = 1'b1;
                    r.ack_seq = last_seq + 4'd1;
                    if (!more_follow)
                    begin
                        r.finished = 1'b1;
                        r.status = 1'b1;
                    end
                end
            end
            if (r.finished)
                clear_session();
            frame_actions_q.push_back(r);
            return r != '0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        // Compares one result request with the oldest expected actions.
        task check_action(logic [OUT_DATA_W-1:0] data, logic last);
            tp20_result_t want;
            if (frame_actions_q.size() == 0)
            begin
                report($sformatf("result 0x%02h with no frame outstanding", data));
                return;
            end
            want = frame_actions_q.pop_front();
            compare_field("store_frame", int'(data[0]), int'(want.store_frame));
            compare_field("send_keepalive", int'(data[1]), int'(want.send_keepalive));
            compare_field("send_ack", int'(data[2]), int'(want.send_ack));
            compare_field("ack_seq", int'(data[6:3]), int'(want.ack_seq));
            compare_field("status", int'(data[7]), int'(want.status));
            compare_field("finished", int'(last), int'(want.finished));
        endtask
    endclass

    tp20_session_tracker tracker;
    int cycle_count = 0;
    int acted_frames = 0;
    bit src_quiet = 1'b0;
    bit hold_off_req = 1'b0;

    tp20_frame_receiver_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        if ($urandom_range(0, 9) < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tp20_item_t make_frame(int len, int op, int lh, int ll,
                                              int svc, int code);
        tp20_item_t f;
        f.frame_length = LEN_W'(len);
        f.op_byte = 8'(op);
        f.len_high_byte = 8'(lh);
        f.len_low_byte = 8'(ll);
        f.service_byte = 8'(svc);
        f.code_byte = 8'(code);
        return f;
    endfunction

    // Offers one frame, possibly after a gap, and waits for its acceptance.
    task automatic send_frame(input tp20_item_t f);
        int gap;
        gap = (src_quiet || $urandom_range(0, 99) < 65) ? 0 : pick_pause();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'(f);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (tracker.note_frame(f))
            acted_frames++;
    endtask

    // Stops offering frames until every expected result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_busy_limit(input logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.busy_limit = value;
    endtask

    task automatic send_busy_run(input int count);
        for (int i = 0; i < count; i++)
            send_frame(make_frame($urandom_range(7, 31), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  int'(NEG_RESP), int'(RESP_PENDING)));
    endtask

    // A first frame followed by continuations until the message closes.
    task automatic send_message();
        int         len;
        int         lh;
        int         sent;
        logic [3:0] seq;
        seq = 4'($urandom_range(0, 15));
        lh = $urandom_range(0, 1) << 7;
        lh = lh | ($urandom_range(0, 99) < 3 ? $urandom_range(0, 15) : 0);
        lh = lh | ($urandom_range(0, 7) << 4);
        len = $urandom_range(7, 16);
        send_frame(make_frame(len, int'({4'($urandom_range(0, 15)), seq}), lh,
                              $urandom_range(0, 80), $urandom_range(0, 255),
                              $urandom_range(0, 255)));
        sent = 0;
        while (tracker.in_message && sent < MAX_CONT_FRAMES)
        begin
            seq = seq + 4'd1;
            case ($urandom_range(0, 99)) inside
                [0:89]:  send_frame(make_frame($urandom_range(5, 16),
                                               int'({4'($urandom_range(0, 15)), seq}),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255)));
                [90:93]: send_frame(make_frame(0, $urandom_range(0, 255),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255)));
                default: send_frame(make_frame($urandom_range(0, 31),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255)));
            endcase
            sent++;
        end
        if (tracker.in_message)
            send_frame(make_frame(0, 0, 0, 0, 0, 0));
    endtask

    // Random mix of session traffic until enough frames were acted on.
    task automatic run_random(input int count);
        int goal;
        int kind;
        int n;
        goal = acted_frames + count;
        while (acted_frames < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                src_quiet = !src_quiet;
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                send_message();
            end
            else if (kind < 55)
            begin
                n = $urandom_range(1, 11);
                for (int i = 0; i < n; i++)
                    send_frame(make_frame($urandom_range(1, 4), int'(OP_KEEPALIVE),
                                          $urandom_range(0, 255), $urandom_range(0, 255),
                                          $urandom_range(0, 255), $urandom_range(0, 255)));
            end
            else if (kind < 67)
            begin
                send_busy_run($urandom_range(1, 4));
            end
            else if (kind < 72)
            begin
                send_frame(make_frame($urandom_range(8, 31), int'(OP_WAIT),
                                      $urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 255)));
            end
            else if (kind < 77)
            begin
                send_frame(make_frame(0, $urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 255)));
            end
            else
            begin
                // Noise, biased toward the opcodes and codes that matter.
                n = $urandom_range(0, 2);
                send_frame(make_frame($urandom_range(0, 31),
                                      n == 0 ? int'(OP_WAIT)
                                             : n == 1 ? int'(OP_KEEPALIVE)
                                                      : int'($urandom_range(0, 255)),
                                      $urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 9) < 3 ? int'(NEG_RESP)
                                                               : int'($urandom_range(0, 255)),
                                      $urandom_range(0, 9) < 3 ? int'(RESP_PENDING)
                                                               : int'($urandom_range(0, 255))));
            end
        end
    endtask

    // Result side: checks each accepted result and stalls at random.
    initial
    begin : result_sink
        int stall_left;
        bit calm;
        stall_left = 0;
        calm = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_action(m_tdata, m_tlast);
            if ($urandom_range(0, 99) == 0)
                calm = !calm;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_pause();
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus: directed frames, then random phases under several busy limits.
    initial
    begin : stimulus
        tracker = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Timeout between messages, keep-alives and an ignored short frame.
        send_frame(make_frame(0, 0, 0, 0, 0, 0));
        send_frame(make_frame(4, int'(OP_KEEPALIVE), 0, 0, 0, 0));
        send_frame(make_frame(1, int'(OP_KEEPALIVE), 'hFF, 'hFF, 'hFF, 'hFF));
        send_frame(make_frame(3, 'h00, 0, 0, int'(NEG_RESP), int'(RESP_PENDING)));
        // Busy response reaching the reset limit of one.
        send_frame(make_frame(7, 'hFF, 0, 0, int'(NEG_RESP), int'(RESP_PENDING)));
        // Busy pattern in a frame too short to count: a complete first frame.
        send_frame(make_frame(6, 'h00, 'h00, 'h00, int'(NEG_RESP), int'(RESP_PENDING)));
        // Wait frame, and the wait opcode in a frame too short for it.
        send_frame(make_frame(8, int'(OP_WAIT), 0, 0, 0, 0));
        send_frame(make_frame(7, int'(OP_WAIT), 'h80, 'h01, 0, 0));
        // Overlong first frame with the largest length, a continuation shorter than its header,
        // then a timeout inside the message with more blocks to follow.
        send_frame(make_frame(31, 'h3C, 'h8F, 'hFF, 'hFF, 'hFF));
        send_frame(make_frame(2, 'h0D, 0, 0, 0, 0));
        send_frame(make_frame(31, 'hFE, 0, 0, 0, 0));
        send_frame(make_frame(0, 0, 0, 0, 0, 0));
        // Message completed by its continuations, last block.
        send_frame(make_frame(8, 'h4E, 'h00, 'h14, 0, 0));
        send_frame(make_frame(16, 'h2F, 0, 0, 0, 0));
        send_frame(make_frame(16, 'h20, 0, 0, 0, 0));
        // First frame shorter than its header wraps the received length.
        send_frame(make_frame(5, 'h07, 'h0F, 'hFF, 0, 0));
        // Keep-alives up to the limit.
        for (int i = 0; i < 10; i++)
            send_frame(make_frame(2, int'(OP_KEEPALIVE), 0, 0, 0, 0));
        // Every field at its top value, then a closing timeout.
        send_frame(make_frame(31, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF));
        send_frame(make_frame(0, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF));
        drain_results();

        // Busy limit of zero is reached only after the counter wraps.
        write_busy_limit(8'd0);
        src_quiet = 1'b1;
        send_busy_run(256);
        src_quiet = 1'b0;
        run_random(200);
        drain_results();

        // Largest busy limit, with the result side held off for a long stretch.
        write_busy_limit(8'd255);
        hold_off_req = 1'b1;
        src_quiet = 1'b1;
        send_busy_run(256);
        src_quiet = 1'b0;
        drain_results();
        run_random(200);
        drain_results();

        write_busy_limit(8'd2);
        run_random(250);
        drain_results();

        write_busy_limit(8'($urandom_range(3, 254)));
        run_random(250);
        drain_results();

        write_busy_limit(8'd1);
        run_random(250);
        drain_results();

        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tp20_pkg.sv
rtl/tp20_step.sv
rtl/tp20_frame_receiver_unit.sv
tb/tb_top.sv
